>>> src/lpmr_pkg.sv
`timescale 1ns / 1ps

package lpmr_pkg;

  localparam int unsigned DefTableDepth = 32;
  localparam int unsigned DefNumPorts   = 16;

  localparam int unsigned AddrW   = 32;
  localparam int unsigned LenW    = 6;
  localparam int unsigned PortW   = 4;
  localparam int unsigned TtlW    = 8;
  localparam int unsigned StatusW = 3;

  localparam logic [LenW-1:0] MaxPrefixLen = LenW'(32);

  typedef enum logic {
    REQ_ADD   = 1'b0,
    REQ_ROUTE = 1'b1
  } req_e;

  typedef enum logic [StatusW-1:0] {
    STS_FORWARDED   = 3'd0,
    STS_NO_ROUTE    = 3'd1,
    STS_TTL_EXPIRED = 3'd2,
    STS_ADDED       = 3'd3,
    STS_FULL        = 3'd4
  } status_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_ADD,
    ST_SCAN,
    ST_FINISH
  } state_e;

  // One stored route.
  typedef struct packed {
    logic [AddrW-1:0] prefix;
    logic [LenW-1:0]  len;
    logic             has_hop;
    logic [AddrW-1:0] hop;
    logic [PortW-1:0] port;
  } route_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic capture;
    logic add_write;
    logic scan_issue;
    logic load_out;
  } ctrl_cmd_t;

  // Status from the datapath back to the controller.
  typedef struct packed {
    logic issue_done;
    logic rd_pending;
    logic out_free;
  } dp_status_t;

  // Network mask with the top len bits set; lengths of 32 and above give all ones.
  function automatic logic [AddrW-1:0] prefix_mask(input logic [LenW-1:0] len);
    logic [AddrW-1:0] mask;
    if (len >= MaxPrefixLen) begin
      mask = '1;
    end else begin
      mask = ~({AddrW{1'b1}} >> len);
    end
    return mask;
  endfunction

endpackage

>>> src/lpmr_ctrl.sv
`timescale 1ns / 1ps

module lpmr_ctrl import lpmr_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  input  logic       req_type_i,
  input  dp_status_t dp_sts_i,
  output logic       in_ready_o,
  output ctrl_cmd_t  cmd_o
);

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          state_d = (req_e'(req_type_i) == REQ_ADD) ? ST_ADD : ST_SCAN;
        end
      end
      ST_ADD: begin
        state_d = ST_FINISH;
      end
      ST_SCAN: begin
        if (dp_sts_i.issue_done && !dp_sts_i.rd_pending) begin
          state_d = ST_FINISH;
        end
      end
      ST_FINISH: begin
        if (dp_sts_i.out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready_o = 1'b0;
    cmd_o      = '0;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o    = 1'b1;
        cmd_o.capture = in_valid_i;
      end
      ST_ADD: begin
        cmd_o.add_write = 1'b1;
      end
      ST_SCAN: begin
        cmd_o.scan_issue = !dp_sts_i.issue_done;
      end
      ST_FINISH: begin
        cmd_o.load_out = dp_sts_i.out_free;
      end
      default: begin
        in_ready_o = 1'b0;
      end
    endcase
  end

endmodule

>>> src/lpmr_dp.sv
`timescale 1ns / 1ps

module lpmr_dp import lpmr_pkg::*; #(
  parameter int unsigned TABLE_DEPTH = DefTableDepth,
  parameter int unsigned NUM_PORTS   = DefNumPorts
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  ctrl_cmd_t            cmd_i,
  output dp_status_t           dp_sts_o,
  input  logic                 req_type_i,
  input  logic [AddrW-1:0]     prefix_value_i,
  input  logic [LenW-1:0]      prefix_bits_i,
  input  logic                 hop_present_i,
  input  logic [AddrW-1:0]     hop_address_i,
  input  logic [PortW-1:0]     port_index_i,
  input  logic [AddrW-1:0]     dest_address_i,
  input  logic [TtlW-1:0]      hops_left_i,
  input  logic                 out_ready_i,
  output logic                 out_valid_o,
  output logic [StatusW-1:0]   status_o,
  output logic [PortW-1:0]     out_port_o,
  output logic [AddrW-1:0]     out_hop_o,
  output logic [TtlW-1:0]      out_ttl_o
);

  localparam int unsigned IdxW  = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int unsigned CntW  = $clog2(TABLE_DEPTH + 1);
  localparam int unsigned PortCmpW = 9;

  // Captured request.
  logic             req_route_q;
  logic [AddrW-1:0] prefix_q;
  logic [LenW-1:0]  len_q;
  logic             has_hop_q;
  logic [AddrW-1:0] hop_q;
  logic [PortW-1:0] port_q;
  logic [AddrW-1:0] dest_q;
  logic [TtlW-1:0]  ttl_q;

  route_t mem_q [TABLE_DEPTH];
  route_t rd_q;
  route_t wr_entry;

  logic [CntW-1:0] count_q;
  logic [CntW-1:0] issue_idx_q;
  logic            rd_vld_q;
  logic            full_q;
  logic            table_full;

  logic             found_q;
  logic [LenW-1:0]  best_len_q;
  logic             best_has_hop_q;
  logic [AddrW-1:0] best_hop_q;
  logic [PortW-1:0] best_port_q;
  logic             hit;
  logic             take;

  logic                out_valid_q;
  logic [StatusW-1:0]  out_status_q;
  logic [PortW-1:0]    out_port_q;
  logic [AddrW-1:0]    out_hop_q;
  logic [TtlW-1:0]     out_ttl_q;
  status_e             res_status;
  logic [PortW-1:0]    res_port;
  logic [AddrW-1:0]    res_hop;
  logic [TtlW-1:0]     res_ttl;

  assign table_full = (count_q == CntW'(TABLE_DEPTH));

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      req_route_q <= req_type_i;
      prefix_q    <= prefix_value_i;
      len_q       <= prefix_bits_i;
      has_hop_q   <= hop_present_i;
      hop_q       <= hop_address_i;
      port_q      <= port_index_i;
      dest_q      <= dest_address_i;
      ttl_q       <= hops_left_i;
    end
  end

  // Saturate length and port before the route is stored.
  always_comb begin
    wr_entry.prefix  = prefix_q;
    wr_entry.len     = (len_q > MaxPrefixLen) ? MaxPrefixLen : len_q;
    wr_entry.has_hop = has_hop_q;
    wr_entry.hop     = hop_q;
    if ({{(PortCmpW-PortW){1'b0}}, port_q} >= PortCmpW'(NUM_PORTS)) begin
      wr_entry.port = PortW'(NUM_PORTS - 1);
    end else begin
      wr_entry.port = port_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.add_write && !table_full) begin
      mem_q[count_q[IdxW-1:0]] <= wr_entry;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.scan_issue) begin
      rd_q <= mem_q[issue_idx_q[IdxW-1:0]];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      issue_idx_q <= '0;
      rd_vld_q    <= 1'b0;
    end else begin
      rd_vld_q <= cmd_i.scan_issue;
      if (cmd_i.add_write && !table_full) begin
        count_q <= count_q + CntW'(1);
      end
      if (cmd_i.capture) begin
        issue_idx_q <= '0;
      end else if (cmd_i.scan_issue) begin
        issue_idx_q <= issue_idx_q + CntW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.add_write) begin
      full_q <= table_full;
    end
  end

  // A strictly longer match replaces the best one, so the earliest entry keeps a tie.
  assign hit  = (((rd_q.prefix ^ dest_q) & prefix_mask(rd_q.len)) == '0);
  assign take = rd_vld_q && hit && (!found_q || (rd_q.len > best_len_q));

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      found_q <= 1'b0;
    end else if (take) begin
      found_q        <= 1'b1;
      best_len_q     <= rd_q.len;
      best_has_hop_q <= rd_q.has_hop;
      best_hop_q     <= rd_q.hop;
      best_port_q    <= rd_q.port;
    end
  end

  always_comb begin
    res_port = '0;
    res_hop  = '0;
    res_ttl  = '0;
    if (!req_route_q) begin
      res_status = full_q ? STS_FULL : STS_ADDED;
    end else if (!found_q) begin
      res_status = STS_NO_ROUTE;
    end else if (ttl_q <= TtlW'(1)) begin
      res_status = STS_TTL_EXPIRED;
    end else begin
      res_status = STS_FORWARDED;
      res_port   = best_port_q;
      res_hop    = best_has_hop_q ? best_hop_q : dest_q;
      res_ttl    = ttl_q - TtlW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.load_out) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_out) begin
      out_status_q <= res_status;
      out_port_q   <= res_port;
      out_hop_q    <= res_hop;
      out_ttl_q    <= res_ttl;
    end
  end

  assign dp_sts_o.issue_done = (issue_idx_q == count_q);
  assign dp_sts_o.rd_pending = rd_vld_q;
  assign dp_sts_o.out_free   = !out_valid_q || out_ready_i;

  assign out_valid_o = out_valid_q;
  assign status_o    = out_status_q;
  assign out_port_o  = out_port_q;
  assign out_hop_o   = out_hop_q;
  assign out_ttl_o   = out_ttl_q;

endmodule

>>> src/longest_prefix_match_router_unit.sv
`timescale 1ns / 1ps
// Channel   Direction  Handshake              Payload
// request   in         in_valid_i/in_ready_o  req_type, prefix, length, hop, port, dest, ttl
// result    out        out_valid_o/out_ready_i status, out_port, out_hop, out_ttl
//
// An add request writes the table and then loads its result register, and a
// route request on an empty table finds nothing to scan and moves on to the
// result load. Otherwise a route request scans the N stored routes: the scan
// reads one table entry per cycle through the single read port of the route
// memory, then waits for the last registered read to come back and for its
// compare to settle before the result loads. The next request can be accepted
// in the cycle after the result register loads. Reset clears the route count,
// the scan index, the read and output valid flags and the control state; the
// route memory holds no reset value. The block takes one request at a time,
// and a finished result waits in the output register while the next request
// is accepted and worked on; a stalled output only holds back the final step.

module longest_prefix_match_router_unit import lpmr_pkg::*; #(
  parameter int unsigned TABLE_DEPTH = DefTableDepth,
  parameter int unsigned NUM_PORTS   = DefNumPorts
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic               req_type_i,
  input  logic [AddrW-1:0]   prefix_value_i,
  input  logic [LenW-1:0]    prefix_bits_i,
  input  logic               hop_present_i,
  input  logic [AddrW-1:0]   hop_address_i,
  input  logic [PortW-1:0]   port_index_i,
  input  logic [AddrW-1:0]   dest_address_i,
  input  logic [TtlW-1:0]    hops_left_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [StatusW-1:0] status_o,
  output logic [PortW-1:0]   out_port_o,
  output logic [AddrW-1:0]   out_hop_o,
  output logic [TtlW-1:0]    out_ttl_o
);

  // The controller steps each transaction through capture, table write or
  // scan, and result load; the datapath holds the route memory, the running
  // best match and the output register.
  ctrl_cmd_t  cmd;
  dp_status_t dp_sts;

  lpmr_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .req_type_i (req_type_i),
    .dp_sts_i   (dp_sts),
    .in_ready_o (in_ready_o),
    .cmd_o      (cmd)
  );

  lpmr_dp #(
    .TABLE_DEPTH (TABLE_DEPTH),
    .NUM_PORTS   (NUM_PORTS)
  ) u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .dp_sts_o       (dp_sts),
    .req_type_i     (req_type_i),
    .prefix_value_i (prefix_value_i),
    .prefix_bits_i  (prefix_bits_i),
    .hop_present_i  (hop_present_i),
    .hop_address_i  (hop_address_i),
    .port_index_i   (port_index_i),
    .dest_address_i (dest_address_i),
    .hops_left_i    (hops_left_i),
    .out_ready_i    (out_ready_i),
    .out_valid_o    (out_valid_o),
    .status_o       (status_o),
    .out_port_o     (out_port_o),
    .out_hop_o      (out_hop_o),
    .out_ttl_o      (out_ttl_o)
  );

endmodule

>>> src/lpmr_checker.sv
`timescale 1ns / 1ps

module lpmr_checker import lpmr_pkg::*; (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               in_valid_i,
  input logic               in_ready_o,
  input logic               out_valid_o,
  input logic               out_ready_i,
  input logic [StatusW-1:0] status_o,
  input logic [PortW-1:0]   out_port_o,
  input logic [AddrW-1:0]   out_hop_o,
  input logic [TtlW-1:0]    out_ttl_o
);

  // A stalled result keeps its status.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(status_o))
    else $error("stalled result changed");

  // One transaction at a time: ready drops right after an acceptance.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("request accepted while busy");

  // Results that do not forward carry zero fields.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (status_o != STS_FORWARDED) |->
      (out_port_o == '0) && (out_hop_o == '0) && (out_ttl_o == '0))
    else $error("non-forward result has nonzero fields");

  // A forwarded datagram had TTL of at least two, so the new TTL is 1 to 254.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (status_o == STS_FORWARDED) |->
      (out_ttl_o != '0) && (out_ttl_o != '1))
    else $error("forwarded TTL out of range");

endmodule

bind longest_prefix_match_router_unit lpmr_checker u_lpmr_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_ready_o  (in_ready_o),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .status_o    (status_o),
  .out_port_o  (out_port_o),
  .out_hop_o   (out_hop_o),
  .out_ttl_o   (out_ttl_o)
);

>>> sim/lpmr_checker.sv
`timescale 1ns / 1ps

module lpmr_scoreboard import lpmr_pkg::*; #(
  parameter int unsigned TABLE_DEPTH = DefTableDepth,
  parameter int unsigned NUM_PORTS   = DefNumPorts
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  input  logic               in_ready_i,
  input  logic               req_type_i,
  input  logic [AddrW-1:0]   prefix_value_i,
  input  logic [LenW-1:0]    prefix_bits_i,
  input  logic               hop_present_i,
  input  logic [AddrW-1:0]   hop_address_i,
  input  logic [PortW-1:0]   port_index_i,
  input  logic [AddrW-1:0]   dest_address_i,
  input  logic [TtlW-1:0]    hops_left_i,
  input  logic               out_valid_i,
  input  logic               out_ready_i,
  input  logic [StatusW-1:0] status_i,
  input  logic [PortW-1:0]   out_port_i,
  input  logic [AddrW-1:0]   out_hop_i,
  input  logic [TtlW-1:0]    out_ttl_i,
  output int unsigned        fail_count_o,
  output int unsigned        pending_o
);

  typedef struct packed {
    status_e          status;
    logic [PortW-1:0] port;
    logic [AddrW-1:0] hop;
    logic [TtlW-1:0]  ttl;
  } outcome_t;

  route_t      route_table [TABLE_DEPTH];
  int unsigned route_count;
  outcome_t    expected_outcomes [$];

  // Applies one request to the shadow route table and returns its outcome.
  function automatic outcome_t resolve_request(
    input req_e             kind,
    input logic [AddrW-1:0] prefix,
    input logic [LenW-1:0]  bits,
    input logic             has_hop,
    input logic [AddrW-1:0] hop,
    input logic [PortW-1:0] port,
    input logic [AddrW-1:0] dest,
    input logic [TtlW-1:0]  ttl
  );
    outcome_t         res;
    route_t           entry;
    logic [AddrW-1:0] mask;
    logic             found;
    int unsigned      best;
    int unsigned      best_len;
    int unsigned      len;

    res = '0;
    if (kind == REQ_ADD) begin
      if (route_count >= TABLE_DEPTH) begin
        res.status = STS_FULL;
      end else begin
        entry.prefix  = prefix;
        entry.len     = (bits > 6'd32) ? 6'd32 : bits;
        entry.has_hop = has_hop;
        entry.hop     = hop;
        entry.port    = (int'(port) >= NUM_PORTS) ? PortW'(NUM_PORTS - 1) : port;
        route_table[route_count] = entry;
        route_count++;
        res.status = STS_ADDED;
      end
    end else begin
      found    = 1'b0;
      best     = 0;
      best_len = 0;
      for (int unsigned i = 0; i < route_count; i++) begin
        len = 32'(route_table[i].len);
        // A shift by the full width yields zero, so length 0 matches everything.
        mask = {AddrW{1'b1}} << (AddrW - len);
        if (((route_table[i].prefix ^ dest) & mask) == '0) begin
          if (!found || len > best_len) begin
            found    = 1'b1;
            best     = i;
            best_len = len;
          end
        end
      end
      if (!found) begin
        res.status = STS_NO_ROUTE;
      end else if (ttl <= 8'd1) begin
        res.status = STS_TTL_EXPIRED;
      end else begin
        res.status = STS_FORWARDED;
        res.port   = route_table[best].port;
        res.hop    = route_table[best].has_hop ? route_table[best].hop : dest;
        res.ttl    = ttl - 8'd1;
      end
    end
    return res;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    outcome_t    want;
    int unsigned errs;
    if (!rst_ni) begin
      route_count = 0;
      expected_outcomes.delete();
      fail_count_o <= 0;
      pending_o    <= 0;
    end else begin
      errs = 0;
      // The result leaving at this edge is always older than a request entering at it.
      if (out_valid_i && out_ready_i) begin
        if (expected_outcomes.size() == 0) begin
          $display("%0t: result with nothing expected, expected none, actual status %0d",
                   $time, status_i);
          errs++;
        end else begin
          want = expected_outcomes.pop_front();
          if (status_i !== want.status) begin
            $display("%0t: status mismatch, expected %0d, actual %0d",
                     $time, want.status, status_i);
            errs++;
          end
          if (out_port_i !== want.port) begin
            $display("%0t: out_port mismatch, expected %0d, actual %0d",
                     $time, want.port, out_port_i);
            errs++;
          end
          if (out_hop_i !== want.hop) begin
            $display("%0t: out_hop mismatch, expected %h, actual %h",
                     $time, want.hop, out_hop_i);
            errs++;
          end
          if (out_ttl_i !== want.ttl) begin
            $display("%0t: out_ttl mismatch, expected %0d, actual %0d",
                     $time, want.ttl, out_ttl_i);
            errs++;
          end
        end
      end
      if (in_valid_i && in_ready_i) begin
        expected_outcomes.insert(expected_outcomes.size(),
                                 resolve_request(req_e'(req_type_i), prefix_value_i,
                                                 prefix_bits_i, hop_present_i,
                                                 hop_address_i, port_index_i,
                                                 dest_address_i, hops_left_i));
      end
      fail_count_o <= fail_count_o + errs;
      pending_o    <= expected_outcomes.size();
    end
  end

endmodule

>>> sim/testbench.sv
`timescale 1ns / 1ps

// Top of the router testbench. It only generates stimulus and gives the
// verdict; the checker instance beside the router predicts and compares
// every transaction on both channels.
module testbench;
  import lpmr_pkg::*;

  localparam int unsigned TableDepth  = DefTableDepth;
  localparam int unsigned HoldCycles  = 100;
  localparam int unsigned DrainCycles = 40;
  localparam int unsigned CycleLimit  = 300000;

  // One request as the sender sees it, all fields of both kinds.
  typedef struct packed {
    req_e             kind;
    logic [AddrW-1:0] prefix;
    logic [LenW-1:0]  bits;
    logic             has_hop;
    logic [AddrW-1:0] hop;
    logic [PortW-1:0] port;
    logic [AddrW-1:0] dest;
    logic [TtlW-1:0]  ttl;
  } request_t;

  logic               clk_i          = 1'b0;
  logic               rst_ni         = 1'b0;
  logic               in_valid_i     = 1'b0;
  logic               in_ready_o;
  logic               req_type_i     = 1'b0;
  logic [AddrW-1:0]   prefix_value_i = '0;
  logic [LenW-1:0]    prefix_bits_i  = '0;
  logic               hop_present_i  = 1'b0;
  logic [AddrW-1:0]   hop_address_i  = '0;
  logic [PortW-1:0]   port_index_i   = '0;
  logic [AddrW-1:0]   dest_address_i = '0;
  logic [TtlW-1:0]    hops_left_i    = '0;
  logic               out_valid_o;
  logic               out_ready_i    = 1'b0;
  logic [StatusW-1:0] status_o;
  logic [PortW-1:0]   out_port_o;
  logic [AddrW-1:0]   out_hop_o;
  logic [TtlW-1:0]    out_ttl_o;

  int unsigned fail_count;
  int unsigned pending;
  int unsigned cycle_count = 0;

  // When calm is set, neither side idles any more.
  logic        calm      = 1'b0;
  // Each increment asks the result sink for one long hold-off.
  int unsigned hold_reqs = 0;

  // Routes the sender believes it has stored, kept only to aim destinations
  // at real prefixes. Lengths are kept saturated to 32.
  logic [AddrW-1:0] known_prefix [TableDepth];
  int unsigned      known_len    [TableDepth];
  int unsigned      known_n      = 0;

  longest_prefix_match_router_unit DUT (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .req_type_i     (req_type_i),
    .prefix_value_i (prefix_value_i),
    .prefix_bits_i  (prefix_bits_i),
    .hop_present_i  (hop_present_i),
    .hop_address_i  (hop_address_i),
    .port_index_i   (port_index_i),
    .dest_address_i (dest_address_i),
    .hops_left_i    (hops_left_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .status_o       (status_o),
    .out_port_o     (out_port_o),
    .out_hop_o      (out_hop_o),
    .out_ttl_o      (out_ttl_o)
  );

  lpmr_scoreboard route_checker (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_ready_i     (in_ready_o),
    .req_type_i     (req_type_i),
    .prefix_value_i (prefix_value_i),
    .prefix_bits_i  (prefix_bits_i),
    .hop_present_i  (hop_present_i),
    .hop_address_i  (hop_address_i),
    .port_index_i   (port_index_i),
    .dest_address_i (dest_address_i),
    .hops_left_i    (hops_left_i),
    .out_valid_i    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .status_i       (status_o),
    .out_port_i     (out_port_o),
    .out_hop_i      (out_hop_o),
    .out_ttl_i      (out_ttl_o),
    .fail_count_o   (fail_count),
    .pending_o      (pending)
  );

  always begin
    clk_i = 1'b0;
    #4;
    clk_i = 1'b1;
    #4;
  end

  // Watchdog. The slowest correct run is roughly 450 transactions, each a
  // table scan plus random idling on each side, far below CycleLimit, so
  // this limit only trips on a hang.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CycleLimit) begin
      $display("Verification failed");
      $finish;
    end
  end

  // Result sink. It stalls in random bursts, serves long hold-offs on
  // request, and stays ready all the time once the run turns calm.
  initial begin : result_sink
    int unsigned holds_served;
    holds_served = 0;
    wait (rst_ni);
    forever begin
      @(posedge clk_i);
      if (hold_reqs != holds_served) begin
        // A long stall lets the output register and the working request both
        // fill up, so the router has to drop in_ready_o.
        holds_served = hold_reqs;
        out_ready_i <= 1'b0;
        repeat (HoldCycles) @(posedge clk_i);
        out_ready_i <= 1'b1;
      end else if (!calm && $urandom_range(0, 5) == 0) begin
        out_ready_i <= 1'b0;
        repeat ($urandom_range(1, 8)) @(posedge clk_i);
        out_ready_i <= 1'b1;
      end else begin
        out_ready_i <= 1'b1;
      end
    end
  end

  // Mask with the top len bits set; a shift by the full width gives zero.
  function automatic logic [AddrW-1:0] span_mask(input int unsigned len);
    return {AddrW{1'b1}} << (AddrW - len);
  endfunction

  // Presents one transaction, possibly after a short idle burst, and returns
  // at the edge where it is accepted. Valid stays high afterwards so that
  // back-to-back transactions need no gap.
  task automatic offer(input request_t req);
    if (!calm && $urandom_range(0, 4) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk_i);
    end
    in_valid_i     <= 1'b1;
    req_type_i     <= req.kind;
    prefix_value_i <= req.prefix;
    prefix_bits_i  <= req.bits;
    hop_present_i  <= req.has_hop;
    hop_address_i  <= req.hop;
    port_index_i   <= req.port;
    dest_address_i <= req.dest;
    hops_left_i    <= req.ttl;
    do @(posedge clk_i); while (!in_ready_o);
  endtask

  // Sender pause: valid drops and nothing is offered until every expected
  // result has been taken.
  task automatic wait_drained();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (pending != 0);
  endtask

  // Route add. The route-request fields carry random values, which the
  // router has to ignore.
  task automatic store_route(input logic [AddrW-1:0] prefix, input logic [LenW-1:0] bits,
                             input logic has_hop, input logic [AddrW-1:0] hop,
                             input logic [PortW-1:0] port);
    request_t req;
    req.kind    = REQ_ADD;
    req.prefix  = prefix;
    req.bits    = bits;
    req.has_hop = has_hop;
    req.hop     = hop;
    req.port    = port;
    req.dest    = $urandom;
    req.ttl     = TtlW'($urandom_range(0, 255));
    if (known_n < TableDepth) begin
      known_prefix[known_n] = prefix;
      known_len[known_n]    = (bits > 6'd32) ? 32 : 32'(bits);
      known_n++;
    end
    offer(req);
  endtask

  // Datagram lookup, with random values in the add-only fields.
  task automatic route_to(input logic [AddrW-1:0] dest, input logic [TtlW-1:0] ttl);
    request_t req;
    req.kind    = REQ_ROUTE;
    req.prefix  = $urandom;
    req.bits    = LenW'($urandom_range(0, 63));
    req.has_hop = 1'($urandom_range(0, 1));
    req.hop     = $urandom;
    req.port    = PortW'($urandom_range(0, 15));
    req.dest    = dest;
    req.ttl     = ttl;
    offer(req);
  endtask

  // Most destinations fall inside a stored prefix, some just outside it by
  // one bit, and the rest anywhere.
  function automatic logic [AddrW-1:0] pick_dest();
    logic [AddrW-1:0] mask;
    logic [AddrW-1:0] dest;
    int unsigned      pick;
    dest = $urandom;
    if (known_n > 0 && $urandom_range(0, 9) < 7) begin
      pick = $urandom_range(0, known_n - 1);
      mask = span_mask(known_len[pick]);
      dest = (known_prefix[pick] & mask) | (dest & ~mask);
      if (known_len[pick] > 0 && $urandom_range(0, 3) == 0) begin
        dest[AddrW - 1 - $urandom_range(0, known_len[pick] - 1)] ^= 1'b1;
      end
    end
    return dest;
  endfunction

  // TTLs lean toward the expiry boundary.
  function automatic logic [TtlW-1:0] pick_ttl();
    int unsigned sel;
    sel = $urandom_range(0, 99);
    if (sel < 15) return 8'd0;
    if (sel < 30) return 8'd1;
    if (sel < 40) return 8'd2;
    if (sel < 45) return 8'd255;
    return TtlW'($urandom_range(0, 255));
  endfunction

  // A random add. Lengths are mostly realistic, some short, some above 32;
  // a third of the prefixes nest inside an existing route so that longer
  // matches compete with shorter ones.
  task automatic random_add();
    logic [AddrW-1:0] base;
    logic [AddrW-1:0] mask;
    logic [LenW-1:0]  len;
    int unsigned      sel;
    int unsigned      pick;
    sel = $urandom_range(0, 99);
    if (sel < 15) begin
      len = LenW'($urandom_range(1, 7));
    end else if (sel < 30) begin
      len = LenW'($urandom_range(33, 63));
    end else begin
      len = LenW'($urandom_range(8, 32));
    end
    base = $urandom;
    if (known_n > 0 && $urandom_range(0, 2) == 0) begin
      pick = $urandom_range(0, known_n - 1);
      mask = span_mask(known_len[pick]);
      base = (known_prefix[pick] & mask) | (base & ~mask);
    end
    store_route(base, len, 1'($urandom_range(0, 1)), $urandom,
                PortW'($urandom_range(0, 15)));
  endtask

  task automatic random_item(input int unsigned add_pct);
    if ($urandom_range(0, 99) < add_pct) begin
      random_add();
    end else begin
      route_to(pick_dest(), pick_ttl());
    end
  endtask

  initial begin : stimulus
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Lookups in an empty table find nothing, whatever the TTL.
    route_to(32'hFFFF_FFFF, 8'd0);
    route_to(32'h0000_0000, 8'd255);

    // A /16 with a next hop, two /24 routes that tie on length, a host route
    // given as length 63, another given as 33, and an all-zero host route.
    store_route(32'hC0A8_0000, 6'd16, 1'b1, 32'h0A0A_0A01, 4'd15);
    store_route(32'hC0A8_0100, 6'd24, 1'b0, 32'hFFFF_FFFF, 4'd3);
    store_route(32'hC0A8_01FF, 6'd24, 1'b1, 32'h0101_0101, 4'd7);
    store_route(32'hFFFF_FFFF, 6'd63, 1'b1, 32'hFFFF_FFFF, 4'd0);
    store_route(32'h0A00_0001, 6'd33, 1'b0, 32'h0000_0000, 4'd9);
    store_route(32'h0000_0000, 6'd32, 1'b1, 32'h0000_0000, 4'd0);

    // The earlier /24 wins the tie and, having no next hop, sends to the
    // destination; outside the /24 the /16 takes over.
    route_to(32'hC0A8_0105, 8'd255);
    route_to(32'hC0A8_0205, 8'd2);
    route_to(32'hC0A8_FFFF, 8'd3);
    // A match with TTL 1 or 0 expires; no match with a low TTL is no route.
    route_to(32'hC0A8_0105, 8'd1);
    route_to(32'hC0A8_0105, 8'd0);
    route_to(32'h0102_0304, 8'd0);
    // Host routes match only their exact address.
    route_to(32'hFFFF_FFFF, 8'd128);
    route_to(32'h0A00_0001, 8'd64);
    route_to(32'h0A00_0003, 8'd64);
    route_to(32'h0000_0000, 8'd255);

    // Fill the table to one short of full while routing. One slot is kept
    // for a default route so that misses stay possible until late.
    for (int i = 0; i < 220; i++) begin
      if (i == 80) begin
        wait_drained();
      end
      if (i == 140) begin
        hold_reqs <= hold_reqs + 1;
      end
      random_item((known_n < TableDepth - 1) ? 25 : 0);
    end
    while (known_n < TableDepth - 1) begin
      random_add();
    end

    // The default route takes the last slot; every later add finds the
    // table full.
    store_route($urandom, 6'd0, 1'($urandom_range(0, 1)), $urandom,
                PortW'($urandom_range(0, 15)));
    for (int i = 0; i < 150; i++) begin
      random_item(15);
    end

    // Final stretch at full speed on both sides.
    calm <= 1'b1;
    for (int i = 0; i < 60; i++) begin
      random_item(10);
    end

    wait_drained();
    repeat (DrainCycles) @(posedge clk_i);
    if (fail_count == 0 && pending == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
